// File: sv/kms_pkg.sv
package kms_pkg;

    localparam int STREAMS_DEF    = 16;
    localparam int KEY_BITS_DEF   = 64;
    localparam int VALUE_BITS_DEF = 48;

    localparam int CFG_W   = 5;
    localparam int COUNT_W = 32;
    localparam int NEXT_W  = 4;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int USER_W  = 2;

    localparam int USER_VALID = 0;
    localparam int USER_SAT   = 1;

    localparam logic [ADDR_W-3:0] REG_STREAM_COUNT = '0;

    typedef struct packed {
        logic clear;
        logic load;
        logic pop;
    } kms_head_cmd_t;

endpackage

// File: sv/kway_merge_sum_equal_keys.sv
// An item accepted from s_axis is held in the input register and, once the output register is free
// or m_axis_tready is high, moves to the output register that drives m_axis_tvalid.
// Throughput: one item per cycle unless m_axis_tready stalls; the source sees next_stream, which
// sets the stream of the following item, so its request round trip sets the practical rate.
// Reset: rst_n is asynchronous and active low; it empties all heads, clears the accumulator and
// the count, and sets stream_count to 1. Writing stream_count restarts the merge the same way.
module kway_merge_sum_equal_keys
    import kms_pkg::*;
#(
    parameter int STREAMS    = STREAMS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int IN_W       = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((KEY_BITS + VALUE_BITS + NEXT_W + COUNT_W + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // Fields from bit 0 up: record_key, record_value, zero fill.
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // Fields from bit 0 up: out_key, out_value, next_stream, distinct_keys, zero fill.
    output logic [OUT_W-1:0]  m_axis_tdata,
    // Fields from bit 0 up: record_valid, value_saturated.
    output logic [USER_W-1:0] m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int IDX_W = $clog2(STREAMS);
    localparam int V_LO  = KEY_BITS;
    localparam int N_LO  = KEY_BITS + VALUE_BITS;
    localparam int C_LO  = N_LO + NEXT_W;

    logic [CFG_W-1:0]      stream_count_reg;
    logic                  cfg_wr;

    logic                  in_valid_reg, in_valid_next;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic [VALUE_BITS-1:0] in_value_reg;
    logic                  in_eos_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;
    logic [USER_W-1:0]     out_user_reg, out_user_next;
    logic                  out_last_reg;

    logic                  step;
    logic                  accept;

    kms_head_cmd_t         cmd;
    logic [IDX_W-1:0]      requested;
    logic                  pop_found;
    logic [KEY_BITS-1:0]   pop_key;
    logic [VALUE_BITS-1:0] pop_value;
    logic [IDX_W-1:0]      pop_idx;
    logic                  heads_empty;

    logic                  res_valid;
    logic [KEY_BITS-1:0]   res_key;
    logic [VALUE_BITS-1:0] res_value;
    logic                  res_sat;
    logic [NEXT_W-1:0]     res_next;
    logic                  res_finished;
    logic [COUNT_W-1:0]    res_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[ADDR_W-1:2] == REG_STREAM_COUNT);

    always_comb
    begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_STREAM_COUNT)
        begin
            prdata = {{(DATA_W - CFG_W){1'b0}}, stream_count_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_count_reg <= CFG_W'(1);
        end
        else if (cfg_wr)
        begin
            stream_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = accept ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_key_reg   <= s_axis_tdata[KEY_BITS-1:0];
            in_value_reg <= s_axis_tdata[N_LO-1:V_LO];
            in_eos_reg   <= s_axis_tlast;
        end
    end

    kms_heads #(
        .STREAMS    (STREAMS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .IDX_W      (IDX_W)
    ) u_heads (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .new_live   (!in_eos_reg),
        .new_key    (in_key_reg),
        .new_value  (in_value_reg),
        .new_idx    (requested),
        .pop_found  (pop_found),
        .pop_key    (pop_key),
        .pop_value  (pop_value),
        .pop_idx    (pop_idx),
        .empty      (heads_empty)
    );

    kms_merge_ctrl #(
        .STREAMS      (STREAMS),
        .KEY_BITS     (KEY_BITS),
        .VALUE_BITS   (VALUE_BITS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (cfg_wr),
        .step         (step),
        .stream_count (stream_count_reg),
        .pop_found    (pop_found),
        .pop_key      (pop_key),
        .pop_value    (pop_value),
        .pop_idx      (pop_idx),
        .cmd          (cmd),
        .requested    (requested),
        .res_valid    (res_valid),
        .res_key      (res_key),
        .res_value    (res_value),
        .res_sat      (res_sat),
        .res_next     (res_next),
        .res_finished (res_finished),
        .res_count    (res_count)
    );

    always_comb
    begin
        out_data_next                     = '0;
        out_data_next[KEY_BITS-1:0]       = res_key;
        out_data_next[N_LO-1:V_LO]        = res_value;
        out_data_next[C_LO-1:N_LO]        = res_next;
        out_data_next[C_LO+COUNT_W-1:C_LO] = res_count;
        out_user_next                     = '0;
        out_user_next[USER_VALID]         = res_valid;
        out_user_next[USER_SAT]           = res_sat;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
            out_last_reg <= res_finished;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    // An emitted record never carries key zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[USER_VALID] |-> m_axis_tdata[KEY_BITS-1:0] != '0)
        else $error("merged record emitted with key zero");

    // Once the finished mark is shown, no head is left live.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> heads_empty)
        else $error("finished while heads are still live");

    // The distinct key count never falls from one result to the next.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && out_valid_reg && !cfg_wr |=>
            m_axis_tdata[C_LO+COUNT_W-1:C_LO] >= $past(m_axis_tdata[C_LO+COUNT_W-1:C_LO]))
        else $error("distinct key count decreased");

endmodule

// File: sv/kms_heads.sv
module kms_heads
    import kms_pkg::*;
#(
    parameter int STREAMS    = STREAMS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int IDX_W      = $clog2(STREAMS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  kms_head_cmd_t         cmd,
    input  logic                  new_live,
    input  logic [KEY_BITS-1:0]   new_key,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic [IDX_W-1:0]      new_idx,
    output logic                  pop_found,
    output logic [KEY_BITS-1:0]   pop_key,
    output logic [VALUE_BITS-1:0] pop_value,
    output logic [IDX_W-1:0]      pop_idx,
    output logic                  empty
);

    // The live heads are kept sorted by key, then by stream index, in a row of cells.
    logic [KEY_BITS-1:0]   key_reg   [STREAMS];
    logic [VALUE_BITS-1:0] value_reg [STREAMS];
    logic [IDX_W-1:0]      idx_reg   [STREAMS];
    logic [STREAMS-1:0]    valid_reg;

    logic [KEY_BITS-1:0]   key_next   [STREAMS];
    logic [VALUE_BITS-1:0] value_next [STREAMS];
    logic [IDX_W-1:0]      idx_next   [STREAMS];
    logic [STREAMS-1:0]    valid_next;

    logic [KEY_BITS-1:0]   ext_key   [STREAMS+1];
    logic [VALUE_BITS-1:0] ext_value [STREAMS+1];
    logic [IDX_W-1:0]      ext_idx   [STREAMS+1];
    logic [STREAMS:0]      ext_valid;

    logic [KEY_BITS-1:0]   prv_key   [STREAMS];
    logic [VALUE_BITS-1:0] prv_value [STREAMS];
    logic [IDX_W-1:0]      prv_idx   [STREAMS];
    logic [STREAMS-1:0]    prv_valid;
    logic [STREAMS-1:0]    prv_lt;

    logic [STREAMS:0]      lt;

    always_comb
    begin
        for (int j = 0; j < STREAMS; j++)
        begin
            ext_key[j]   = key_reg[j];
            ext_value[j] = value_reg[j];
            ext_idx[j]   = idx_reg[j];
            ext_valid[j] = valid_reg[j];
        end
        ext_key[STREAMS]   = '0;
        ext_value[STREAMS] = '0;
        ext_idx[STREAMS]   = '0;
        ext_valid[STREAMS] = 1'b0;
        for (int j = 0; j <= STREAMS; j++)
        begin
            lt[j] = new_live &&
                    (!ext_valid[j] || ({new_key, new_idx} < {ext_key[j], ext_idx[j]}));
        end
    end

    always_comb
    begin
        prv_key[0]   = '0;
        prv_value[0] = '0;
        prv_idx[0]   = '0;
        prv_valid[0] = 1'b0;
        prv_lt[0]    = 1'b0;
        for (int j = 1; j < STREAMS; j++)
        begin
            prv_key[j]   = key_reg[j-1];
            prv_value[j] = value_reg[j-1];
            prv_idx[j]   = idx_reg[j-1];
            prv_valid[j] = valid_reg[j-1];
            prv_lt[j]    = lt[j-1];
        end
    end

    // Insert the new item and, on a pop, shift the row down by one cell.
    always_comb
    begin
        for (int j = 0; j < STREAMS; j++)
        begin
            if (cmd.pop)
            begin
                if (lt[j+1] && lt[j])
                begin
                    key_next[j]   = ext_key[j];
                    value_next[j] = ext_value[j];
                    idx_next[j]   = ext_idx[j];
                    valid_next[j] = ext_valid[j];
                end
                else if (lt[j+1])
                begin
                    key_next[j]   = new_key;
                    value_next[j] = new_value;
                    idx_next[j]   = new_idx;
                    valid_next[j] = 1'b1;
                end
                else
                begin
                    key_next[j]   = ext_key[j+1];
                    value_next[j] = ext_value[j+1];
                    idx_next[j]   = ext_idx[j+1];
                    valid_next[j] = ext_valid[j+1];
                end
            end
            else
            begin
                if (lt[j] && prv_lt[j])
                begin
                    key_next[j]   = prv_key[j];
                    value_next[j] = prv_value[j];
                    idx_next[j]   = prv_idx[j];
                    valid_next[j] = prv_valid[j];
                end
                else if (lt[j])
                begin
                    key_next[j]   = new_key;
                    value_next[j] = new_value;
                    idx_next[j]   = new_idx;
                    valid_next[j] = 1'b1;
                end
                else
                begin
                    key_next[j]   = key_reg[j];
                    value_next[j] = value_reg[j];
                    idx_next[j]   = idx_reg[j];
                    valid_next[j] = valid_reg[j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clear)
        begin
            valid_reg <= '0;
        end
        else if (cmd.load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int j = 0; j < STREAMS; j++)
            begin
                key_reg[j]   <= key_next[j];
                value_reg[j] <= value_next[j];
                idx_reg[j]   <= idx_next[j];
            end
        end
    end

    assign pop_found = lt[0] || valid_reg[0];
    assign pop_key   = lt[0] ? new_key   : key_reg[0];
    assign pop_value = lt[0] ? new_value : value_reg[0];
    assign pop_idx   = lt[0] ? new_idx   : idx_reg[0];
    assign empty     = !valid_reg[0];

endmodule

// File: sv/kms_merge_ctrl.sv
module kms_merge_ctrl
    import kms_pkg::*;
#(
    parameter int STREAMS    = STREAMS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int IDX_W      = $clog2(STREAMS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear,
    input  logic                  step,
    input  logic [CFG_W-1:0]      stream_count,
    input  logic                  pop_found,
    input  logic [KEY_BITS-1:0]   pop_key,
    input  logic [VALUE_BITS-1:0] pop_value,
    input  logic [IDX_W-1:0]      pop_idx,
    output kms_head_cmd_t         cmd,
    output logic [IDX_W-1:0]      requested,
    output logic                  res_valid,
    output logic [KEY_BITS-1:0]   res_key,
    output logic [VALUE_BITS-1:0] res_value,
    output logic                  res_sat,
    output logic [NEXT_W-1:0]     res_next,
    output logic                  res_finished,
    output logic [COUNT_W-1:0]    res_count
);

    localparam int CNT_W = $clog2(STREAMS + 1);

    logic [CNT_W-1:0]      load_index_reg, load_index_next;
    logic [IDX_W-1:0]      requested_reg, requested_next;
    logic                  done_reg, done_next;
    logic [KEY_BITS-1:0]   acc_key_reg, acc_key_next;
    logic [VALUE_BITS-1:0] acc_value_reg, acc_value_next;
    logic                  acc_sat_reg, acc_sat_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic [CNT_W-1:0]      active;
    logic [CNT_W-1:0]      load_inc;
    logic                  loading;
    logic                  load_more;
    logic [VALUE_BITS:0]   sum;

    always_comb
    begin
        if (stream_count == '0)
        begin
            active = CNT_W'(1);
        end
        else if (32'(stream_count) > STREAMS)
        begin
            active = CNT_W'(STREAMS);
        end
        else
        begin
            active = CNT_W'(stream_count);
        end
    end

    assign load_inc  = CNT_W'(load_index_reg + 1'b1);
    assign loading   = load_index_reg < active;
    assign load_more = loading && (load_inc < active);
    assign sum       = {1'b0, acc_value_reg} + {1'b0, pop_value};

    assign cmd.clear = clear;
    assign cmd.load  = step && !done_reg;
    assign cmd.pop   = step && !done_reg && !load_more && pop_found;

    always_comb
    begin
        load_index_next = load_index_reg;
        requested_next  = requested_reg;
        done_next       = done_reg;
        acc_key_next    = acc_key_reg;
        acc_value_next  = acc_value_reg;
        acc_sat_next    = acc_sat_reg;
        count_next      = count_reg;
        res_valid       = 1'b0;
        res_key         = '0;
        res_value       = '0;
        res_sat         = 1'b0;
        res_finished    = 1'b0;

        if (done_reg)
        begin
            res_finished = 1'b1;
        end
        else
        begin
            if (loading)
            begin
                load_index_next = load_inc;
            end
            if (load_more)
            begin
                requested_next = IDX_W'(load_inc);
            end
            else if (!pop_found)
            begin
                res_valid      = acc_key_reg != '0;
                res_finished   = 1'b1;
                acc_key_next   = '0;
                acc_value_next = '0;
                acc_sat_next   = 1'b0;
                requested_next = '0;
                done_next      = 1'b1;
            end
            else
            begin
                requested_next = pop_idx;
                if (pop_key == acc_key_reg)
                begin
                    if (sum[VALUE_BITS])
                    begin
                        acc_value_next = '1;
                        acc_sat_next   = 1'b1;
                    end
                    else
                    begin
                        acc_value_next = sum[VALUE_BITS-1:0];
                    end
                end
                else
                begin
                    res_valid = acc_key_reg != '0;
                    if (count_reg != '1)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    acc_key_next   = pop_key;
                    acc_value_next = pop_value;
                    acc_sat_next   = 1'b0;
                end
            end
            if (res_valid)
            begin
                res_key   = acc_key_reg;
                res_value = acc_value_reg;
                res_sat   = acc_sat_reg;
            end
        end
    end

    assign res_next  = NEXT_W'(requested_next);
    assign res_count = count_next;
    assign requested = requested_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg <= '0;
            requested_reg  <= '0;
            done_reg       <= 1'b0;
            acc_key_reg    <= '0;
            acc_value_reg  <= '0;
            acc_sat_reg    <= 1'b0;
            count_reg      <= '0;
        end
        else if (clear)
        begin
            load_index_reg <= '0;
            requested_reg  <= '0;
            done_reg       <= 1'b0;
            acc_key_reg    <= '0;
            acc_value_reg  <= '0;
            acc_sat_reg    <= 1'b0;
            count_reg      <= '0;
        end
        else if (step)
        begin
            load_index_reg <= load_index_next;
            requested_reg  <= requested_next;
            done_reg       <= done_next;
            acc_key_reg    <= acc_key_next;
            acc_value_reg  <= acc_value_next;
            acc_sat_reg    <= acc_sat_next;
            count_reg      <= count_next;
        end
    end

endmodule
